FILE: rtl/fstw_pkg.sv
// ----------------------------------------------------------------------------
// Structure token walker package
// Token codes, parser mode codes and result event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fstw_pkg;

  // Structure block token words.
  localparam logic [31:0] TokBeginNode = 32'h0000_0001;
  localparam logic [31:0] TokEndNode   = 32'h0000_0002;
  localparam logic [31:0] TokProp      = 32'h0000_0003;
  localparam logic [31:0] TokNop       = 32'h0000_0004;
  localparam logic [31:0] TokEnd       = 32'h0000_0009;

  // Saturation limit of the node name length.
  localparam logic [7:0] NameLenMax = 8'd255;

  // Parser mode, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_TOKEN = 6'b000010,
    MODE_NAME  = 6'b000100,
    MODE_PLEN  = 6'b001000,
    MODE_PNAME = 6'b010000,
    MODE_PDATA = 6'b100000
  } mode_e;

  // Result event codes.
  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_BEGIN     = 4'd1,
    EV_END_NODE  = 4'd2,
    EV_PROP      = 4'd3,
    EV_DATA      = 4'd4,
    EV_DONE      = 4'd5,
    EV_END_TOKEN = 4'd6,
    EV_UNKNOWN   = 4'd7,
    EV_NESTING   = 4'd8,
    EV_TRUNC     = 4'd9
  } event_e;

endpackage

`default_nettype wire

FILE: rtl/fdt_structure_token_walker.sv
// ----------------------------------------------------------------------------
// Flattened devicetree structure token walker
// Parses the structure block one word at a time and emits one result word
// for every accepted input word.
// ----------------------------------------------------------------------------
// Output: a result appears in the output register in the cycle after its word.
// Throughput: one word per cycle while the result channel accepts; the word
// decode, stack shift and counter updates take effect as the result is loaded.
// Reset: the parser is idle until a word marked first_word arrives; the node
// stack is a shift register that needs no clearing.
`default_nettype none

module fdt_structure_token_walker
  import fstw_pkg::*;
#(
  parameter int unsigned MAX_DEPTH   = 16,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input word channel
  input  wire logic                   word_valid_i,
  output      logic                   word_ready_o,
  input  wire logic [31:0]            word_i,
  input  wire logic                   first_word_i,
  input  wire logic                   last_word_i,
  // Result channel
  output      logic                   res_valid_o,
  input  wire logic                   res_ready_i,
  output      logic [3:0]             event_res_o,
  output      logic [OFFSET_BITS-1:0] node_offset_o,
  output      logic [4:0]             level_o,
  output      logic [OFFSET_BITS-1:0] parent_offset_o,
  output      logic [7:0]             name_length_o,
  output      logic [31:0]            prop_length_o,
  output      logic [31:0]            prop_name_offset_o,
  output      logic [31:0]            data_word_o,
  output      logic                   last_data_o,
  output      logic                   finished_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned OffW   = OFFSET_BITS;

  typedef logic [OffW-1:0]   off_t;
  typedef logic [DepthW-1:0] depth_t;

  // Parser state
  mode_e        mode_q, mode_d;
  depth_t       depth_q, depth_d;
  off_t         wpos_q, wpos_d;
  off_t         pend_q, pend_d;
  logic [7:0]   nbc_q, nbc_d;
  logic [31:0]  plen_q, plen_d;
  logic [29:0]  dwl_q, dwl_d;

  // Open node stack, top of stack at entry zero
  off_t         stk_q [MAX_DEPTH];
  logic         push, pop;

  // Result register
  logic         res_valid_q;
  event_e       ev_q, ev_d;
  off_t         node_q, node_d;
  logic [4:0]   lvl_q, lvl_d;
  off_t         par_q, par_d;
  logic [7:0]   nlen_q, nlen_d;
  logic [31:0]  olen_q, olen_d;
  logic [31:0]  pname_q, pname_d;
  logic [31:0]  dword_q, dword_d;
  logic         ldata_q, ldata_d;
  logic         fin_q, fin_d;

  // State as seen after a restart by first_word
  mode_e        mode_e_w;
  depth_t       depth_e;
  off_t         wpos_e;
  off_t         pend_e;
  logic [7:0]   nbc_e;
  logic [31:0]  plen_e;
  logic [29:0]  dwl_e;

  logic         in_fire;
  logic         found;
  logic [2:0]   name_add;
  logic [8:0]   name_sum;

  assign word_ready_o = !res_valid_q || res_ready_i;
  assign in_fire      = word_valid_i && word_ready_o;

  // Restart view of the state.
  always_comb begin
    if (first_word_i) begin
      mode_e_w = MODE_TOKEN;
      depth_e  = '0;
      wpos_e   = '0;
      pend_e   = '0;
      nbc_e    = '0;
      plen_e   = '0;
      dwl_e    = '0;
    end else begin
      mode_e_w = mode_q;
      depth_e  = depth_q;
      wpos_e   = wpos_q;
      pend_e   = pend_q;
      nbc_e    = nbc_q;
      plen_e   = plen_q;
      dwl_e    = dwl_q;
    end
  end

  // Count name bytes ahead of the terminator in this word.
  always_comb begin
    found    = 1'b0;
    name_add = '0;
    for (int s = 0; s < 4; s++) begin
      if (!found) begin
        if (word_i[31-8*s -: 8] == 8'h00) begin
          found = 1'b1;
        end else begin
          name_add = name_add + 3'd1;
        end
      end
    end
    name_sum = {1'b0, nbc_e} + {6'd0, name_add};
  end

  // Word decode and next state.
  always_comb begin
    mode_d  = mode_q;
    depth_d = depth_q;
    wpos_d  = wpos_q;
    pend_d  = pend_q;
    nbc_d   = nbc_q;
    plen_d  = plen_q;
    dwl_d   = dwl_q;
    push    = 1'b0;
    pop     = 1'b0;
    ev_d    = EV_NONE;
    fin_d   = 1'b0;
    node_d  = '0;
    lvl_d   = '0;
    par_d   = '0;
    nlen_d  = '0;
    olen_d  = '0;
    pname_d = '0;
    dword_d = '0;
    ldata_d = 1'b0;

    if (mode_e_w != MODE_IDLE) begin
      mode_d  = mode_e_w;
      depth_d = depth_e;
      pend_d  = pend_e;
      nbc_d   = nbc_e;
      plen_d  = plen_e;
      dwl_d   = dwl_e;
      wpos_d  = wpos_e + off_t'(1);

      unique case (mode_e_w)
        MODE_TOKEN: begin
          priority if (word_i == TokBeginNode) begin
            if (depth_e >= depth_t'(MAX_DEPTH)) begin
              ev_d  = EV_NESTING;
              fin_d = 1'b1;
            end else begin
              pend_d = wpos_e;
              nbc_d  = '0;
              mode_d = MODE_NAME;
            end
          end else if (word_i == TokEndNode) begin
            if (depth_e == '0) begin
              ev_d  = EV_NESTING;
              fin_d = 1'b1;
            end else begin
              // Close the node on top of the stack.
              depth_d = depth_e - depth_t'(1);
              pop     = 1'b1;
              node_d  = stk_q[0];
              lvl_d   = 5'(depth_e - depth_t'(1));
              par_d   = (depth_e > depth_t'(1)) ? stk_q[1] : '0;
              if (depth_e == depth_t'(1)) begin
                ev_d  = EV_DONE;
                fin_d = 1'b1;
              end else begin
                ev_d  = EV_END_NODE;
              end
            end
          end else if (word_i == TokProp) begin
            if (depth_e == '0) begin
              ev_d  = EV_NESTING;
              fin_d = 1'b1;
            end else begin
              mode_d = MODE_PLEN;
            end
          end else if (word_i == TokNop) begin
            ev_d = EV_NONE;
          end else if (word_i == TokEnd) begin
            ev_d  = EV_END_TOKEN;
            fin_d = 1'b1;
          end else begin
            ev_d  = EV_UNKNOWN;
            fin_d = 1'b1;
          end
        end
        MODE_NAME: begin
          nbc_d = name_sum[8] ? NameLenMax : name_sum[7:0];
          if (found && depth_e < depth_t'(MAX_DEPTH)) begin
            // The name is complete: open the node.
            depth_d = depth_e + depth_t'(1);
            push    = 1'b1;
            node_d  = pend_e;
            lvl_d   = 5'(depth_e);
            par_d   = (depth_e != '0) ? stk_q[0] : '0;
            nlen_d  = nbc_d;
            ev_d    = EV_BEGIN;
            mode_d  = MODE_TOKEN;
          end
        end
        MODE_PLEN: begin
          plen_d = word_i;
          mode_d = MODE_PNAME;
        end
        MODE_PNAME: begin
          if (depth_e == '0) begin
            ev_d  = EV_NESTING;
            fin_d = 1'b1;
          end else begin
            node_d  = stk_q[0];
            lvl_d   = 5'(depth_e - depth_t'(1));
            par_d   = (depth_e > depth_t'(1)) ? stk_q[1] : '0;
            olen_d  = plen_e;
            pname_d = word_i;
            ev_d    = EV_PROP;
            if (plen_e == '0) begin
              mode_d = MODE_TOKEN;
            end else begin
              dwl_d  = 30'((plen_e - 32'd1) >> 2);
              mode_d = MODE_PDATA;
            end
          end
        end
        MODE_PDATA: begin
          if (depth_e == '0) begin
            ev_d  = EV_NESTING;
            fin_d = 1'b1;
          end else begin
            node_d  = stk_q[0];
            lvl_d   = 5'(depth_e - depth_t'(1));
            par_d   = (depth_e > depth_t'(1)) ? stk_q[1] : '0;
            olen_d  = plen_e;
            dword_d = word_i;
            ev_d    = EV_DATA;
            if (dwl_e == '0) begin
              ldata_d = 1'b1;
              mode_d  = MODE_TOKEN;
            end else begin
              dwl_d = dwl_e - 30'd1;
            end
          end
        end
        default: begin
          ev_d  = EV_UNKNOWN;
          fin_d = 1'b1;
        end
      endcase

      // A blob that stops early overrides the word's own result.
      if (!fin_d && last_word_i) begin
        node_d  = '0;
        lvl_d   = '0;
        par_d   = '0;
        nlen_d  = '0;
        olen_d  = '0;
        pname_d = '0;
        dword_d = '0;
        ldata_d = 1'b0;
        ev_d    = EV_TRUNC;
        fin_d   = 1'b1;
      end
      if (fin_d) begin
        mode_d = MODE_IDLE;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      depth_q     <= '0;
      wpos_q      <= '0;
      pend_q      <= '0;
      nbc_q       <= '0;
      plen_q      <= '0;
      dwl_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        depth_q <= depth_d;
        wpos_q  <= wpos_d;
        pend_q  <= pend_d;
        nbc_q   <= nbc_d;
        plen_q  <= plen_d;
        dwl_q   <= dwl_d;
      end
      res_valid_q <= in_fire || (res_valid_q && !res_ready_i);
    end
  end

  // Node stack: a push shifts entries down, a pop shifts them up.
  always_ff @(posedge clk_i) begin
    if (in_fire && push) begin
      stk_q[0] <= pend_e;
      for (int i = 1; i < MAX_DEPTH; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (in_fire && pop) begin
      for (int i = 0; i < MAX_DEPTH - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q    <= ev_d;
      node_q  <= node_d;
      lvl_q   <= lvl_d;
      par_q   <= par_d;
      nlen_q  <= nlen_d;
      olen_q  <= olen_d;
      pname_q <= pname_d;
      dword_q <= dword_d;
      ldata_q <= ldata_d;
      fin_q   <= fin_d;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign event_res_o        = ev_q;
  assign node_offset_o      = node_q;
  assign level_o            = lvl_q;
  assign parent_offset_o    = par_q;
  assign name_length_o      = nlen_q;
  assign prop_length_o      = olen_q;
  assign prop_name_offset_o = pname_q;
  assign data_word_o        = dword_q;
  assign last_data_o        = ldata_q;
  assign finished_o         = fin_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Structure token walker testbench
// Streams flattened devicetree structure words into the walker and checks
// every result word against a cycle-free model of the parser. A directed
// opening covers each token kind and the fault paths. Random walks then
// follow, some well formed and some truncated, restarted or corrupted, with
// random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import fstw_pkg::*;

  localparam int unsigned DEPTH_MAX = 16;
  localparam int unsigned OFF_W     = 20;
  localparam int unsigned IDLE_MAX  = 12;
  localparam int unsigned RAND_WORDS = 1750;

  // One expected or observed result word.
  typedef struct packed {
    event_e           ev;
    logic [OFF_W-1:0] node_off;
    logic [4:0]       level;
    logic [OFF_W-1:0] parent_off;
    logic [7:0]       name_len;
    logic [31:0]      prop_size;
    logic [31:0]      prop_name_off;
    logic [31:0]      data;
    logic             last_data;
    logic             finished;
  } walk_result_t;

  // One input word of a prepared walk.
  typedef struct {
    logic [31:0] word;
    logic        first_word;
    logic        last_word;
  } tok_word_t;

  // Parser model plus the queue of results it predicts.
  class fdt_walk_scoreboard;
    mode_e            mode;
    int unsigned      depth;
    logic [OFF_W-1:0] node_stack [DEPTH_MAX];
    logic [OFF_W-1:0] word_pos;
    logic [OFF_W-1:0] pend_off;
    logic [7:0]       name_bytes;
    logic [31:0]      cur_prop_size;
    logic [29:0]      words_left;
    walk_result_t     expected_events [$];
    int unsigned      errors;
    int unsigned      words_parsed;
    int unsigned      words_ignored;
    int unsigned      results_seen;
    int unsigned      event_hits [16];

    function new();
      mode          = MODE_IDLE;
      depth         = 0;
      word_pos      = '0;
      pend_off      = '0;
      name_bytes    = '0;
      cur_prop_size = '0;
      words_left    = '0;
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    // Node fields for the open node at stack index idx.
    function walk_result_t node_fields(int unsigned idx);
      walk_result_t r;
      r            = '0;
      r.node_off   = node_stack[idx];
      r.level      = 5'(idx);
      r.parent_off = (idx != 0) ? node_stack[idx - 1] : '0;
      return r;
    endfunction

    // Advance the parser by one accepted word and queue its result.
    function void note_word(logic [31:0] w, logic start, logic stop);
      walk_result_t     r;
      logic [OFF_W-1:0] pos;
      bit               fin;
      bit               found;
      int               s;
      r     = '0;
      fin   = 1'b0;
      found = 1'b0;
      if (start) begin
        mode          = MODE_TOKEN;
        depth         = 0;
        word_pos      = '0;
        pend_off      = '0;
        name_bytes    = '0;
        cur_prop_size = '0;
        words_left    = '0;
      end
      // With no walk running the word is dropped but still answered.
      if (mode == MODE_IDLE) begin
        expected_events.push_back(r);
        words_ignored++;
        return;
      end
      words_parsed++;
      pos      = word_pos;
      word_pos = pos + 1'b1;

      case (mode)
        MODE_TOKEN: begin
          if (w == TokBeginNode) begin
            if (depth >= DEPTH_MAX) begin
              r.ev = EV_NESTING;
              fin  = 1'b1;
            end else begin
              pend_off   = pos;
              name_bytes = '0;
              mode       = MODE_NAME;
            end
          end else if (w == TokEndNode) begin
            if (depth == 0) begin
              r.ev = EV_NESTING;
              fin  = 1'b1;
            end else begin
              depth--;
              r = node_fields(depth);
              if (depth == 0) begin
                r.ev = EV_DONE;
                fin  = 1'b1;
              end else begin
                r.ev = EV_END_NODE;
              end
            end
          end else if (w == TokProp) begin
            if (depth == 0) begin
              r.ev = EV_NESTING;
              fin  = 1'b1;
            end else begin
              mode = MODE_PLEN;
            end
          end else if (w == TokNop) begin
            r.ev = EV_NONE;
          end else if (w == TokEnd) begin
            r.ev = EV_END_TOKEN;
            fin  = 1'b1;
          end else begin
            r.ev = EV_UNKNOWN;
            fin  = 1'b1;
          end
        end
        MODE_NAME: begin
          // Count name bytes up to the first NUL, high byte first.
          for (s = 0; s < 4; s++) begin
            if (!found) begin
              if (w[31 - 8*s -: 8] == 8'h00) found = 1'b1;
              else if (name_bytes != NameLenMax) name_bytes++;
            end
          end
          if (found && depth < DEPTH_MAX) begin
            node_stack[depth] = pend_off;
            depth++;
            r          = node_fields(depth - 1);
            r.name_len = name_bytes;
            r.ev       = EV_BEGIN;
            mode       = MODE_TOKEN;
          end
        end
        MODE_PLEN: begin
          cur_prop_size = w;
          mode          = MODE_PNAME;
        end
        MODE_PNAME: begin
          if (depth == 0 || depth > DEPTH_MAX) begin
            r.ev = EV_NESTING;
            fin  = 1'b1;
          end else begin
            r               = node_fields(depth - 1);
            r.prop_size     = cur_prop_size;
            r.prop_name_off = w;
            r.ev            = EV_PROP;
            if (cur_prop_size == 32'd0) begin
              mode = MODE_TOKEN;
            end else begin
              words_left = 30'((cur_prop_size - 32'd1) >> 2);
              mode       = MODE_PDATA;
            end
          end
        end
        MODE_PDATA: begin
          if (depth == 0 || depth > DEPTH_MAX) begin
            r.ev = EV_NESTING;
            fin  = 1'b1;
          end else begin
            r           = node_fields(depth - 1);
            r.prop_size = cur_prop_size;
            r.data      = w;
            r.ev        = EV_DATA;
            if (words_left == '0) begin
              r.last_data = 1'b1;
              mode        = MODE_TOKEN;
            end else begin
              words_left--;
            end
          end
        end
        default: begin
          r.ev = EV_UNKNOWN;
          fin  = 1'b1;
        end
      endcase

      // A blob that runs out mid-walk overrides the word's own event.
      if (!fin && stop) begin
        r    = '0;
        r.ev = EV_TRUNC;
        fin  = 1'b1;
      end
      if (fin) mode = MODE_IDLE;
      r.finished = fin;
      expected_events.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_result(walk_result_t got);
      walk_result_t want;
      if (expected_events.size() == 0) begin
        $error("event_res: expected no result, got 0x%0h", got.ev);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      results_seen++;
      event_hits[want.ev]++;
      cmp_field("event_res", 64'(want.ev), 64'(got.ev));
      cmp_field("node_offset", 64'(want.node_off), 64'(got.node_off));
      cmp_field("level", 64'(want.level), 64'(got.level));
      cmp_field("parent_offset", 64'(want.parent_off), 64'(got.parent_off));
      cmp_field("name_length", 64'(want.name_len), 64'(got.name_len));
      cmp_field("prop_length", 64'(want.prop_size), 64'(got.prop_size));
      cmp_field("prop_name_offset", 64'(want.prop_name_off), 64'(got.prop_name_off));
      cmp_field("data_word", 64'(want.data), 64'(got.data));
      cmp_field("last_data", 64'(want.last_data), 64'(got.last_data));
      cmp_field("finished", 64'(want.finished), 64'(got.finished));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   word_valid_i;
  logic                   word_ready_o;
  logic [31:0]            word_i;
  logic                   first_word_i;
  logic                   last_word_i;
  logic                   res_valid_o;
  logic                   res_ready_i;
  logic [3:0]             event_res_o;
  logic [OFF_W-1:0]       node_offset_o;
  logic [4:0]             level_o;
  logic [OFF_W-1:0]       parent_offset_o;
  logic [7:0]             name_length_o;
  logic [31:0]            prop_length_o;
  logic [31:0]            prop_name_offset_o;
  logic [31:0]            data_word_o;
  logic                   last_data_o;
  logic                   finished_o;

  fdt_walk_scoreboard board;
  tok_word_t          walk_q [$];
  int unsigned        tx_gap_max   = IDLE_MAX;
  int unsigned        rx_stall_max = IDLE_MAX;

  fdt_structure_token_walker #(
    .MAX_DEPTH   (DEPTH_MAX),
    .OFFSET_BITS (OFF_W)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .word_valid_i       (word_valid_i),
    .word_ready_o       (word_ready_o),
    .word_i             (word_i),
    .first_word_i       (first_word_i),
    .last_word_i        (last_word_i),
    .res_valid_o        (res_valid_o),
    .res_ready_i        (res_ready_i),
    .event_res_o        (event_res_o),
    .node_offset_o      (node_offset_o),
    .level_o            (level_o),
    .parent_offset_o    (parent_offset_o),
    .name_length_o      (name_length_o),
    .prop_length_o      (prop_length_o),
    .prop_name_offset_o (prop_name_offset_o),
    .data_word_o        (data_word_o),
    .last_data_o        (last_data_o),
    .finished_o         (finished_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(input logic [31:0] w, input logic start, input logic stop);
    int unsigned gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      word_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_valid_i <= 1'b1;
    word_i       <= w;
    first_word_i <= start;
    last_word_i  <= stop;
    do @(posedge clk_i); while (!word_ready_o);
    board.note_word(w, start, stop);
  endtask

  function automatic void push_word(logic [31:0] w);
    tok_word_t t;
    t.word       = w;
    t.first_word = (walk_q.size() == 0);
    t.last_word  = 1'b0;
    walk_q.push_back(t);
  endfunction

  // Name words: len nonzero bytes, a NUL, then padding to a whole word.
  function automatic void push_name(int unsigned len);
    int unsigned nw;
    int unsigned i;
    int unsigned j;
    int unsigned p;
    bit          messy;
    logic [7:0]  name_byte;
    logic [31:0] w;
    messy = 1'($urandom_range(0, 1));
    nw    = len / 4 + 1;
    for (i = 0; i < nw; i++) begin
      w = '0;
      for (j = 0; j < 4; j++) begin
        p = i * 4 + j;
        if (p < len) name_byte = 8'($urandom_range(1, 255));
        else if (p == len) name_byte = 8'h00;
        else name_byte = messy ? 8'($urandom_range(0, 255)) : 8'h00;
        w = {w[23:0], name_byte};
      end
      push_word(w);
    end
  endfunction

  function automatic int unsigned rand_name_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return $urandom_range(252, 300);
    if (r < 10) return 0;
    return $urandom_range(1, 20);
  endfunction

  function automatic void push_prop(logic [31:0] len);
    int unsigned i;
    push_word(TokProp);
    push_word(len);
    push_word($urandom());
    for (i = 0; i < (len + 3) / 4; i++) push_word($urandom());
  endfunction

  function automatic logic [31:0] rand_bad_token();
    logic [31:0] w;
    if ($urandom_range(0, 2) == 0) return TokEnd;
    w = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 15));
    if (w inside {TokBeginNode, TokEndNode, TokProp, TokNop, TokEnd}) w = 32'h0000_0000;
    return w;
  endfunction

  // Build one walk into walk_q: mostly well formed, sometimes broken.
  function automatic void build_walk();
    int unsigned open_n;
    int unsigned steps;
    int unsigned pick;
    int unsigned begin_pct;
    int unsigned k;
    walk_q.delete();
    // A walk that closes or adds to a node before any node is open.
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(0, 2)) push_word(TokNop);
      push_word($urandom_range(0, 1) ? TokEndNode : TokProp);
      return;
    end
    begin_pct = ($urandom_range(0, 4) == 0) ? 70 : 25;
    steps     = $urandom_range(1, (begin_pct == 70) ? 60 : 30);
    push_word(TokBeginNode);
    push_name(rand_name_len());
    open_n = 1;
    while (open_n > 0) begin
      pick = (steps == 0) ? 99 : $urandom_range(0, 99);
      if (steps != 0) steps--;
      if (pick < begin_pct) begin
        // A begin token with the stack full is a nesting fault.
        if (open_n == DEPTH_MAX) begin
          push_word(TokBeginNode);
          break;
        end
        push_word(TokBeginNode);
        push_name(rand_name_len());
        open_n++;
      end else begin
        pick = (steps == 0) ? 99 : $urandom_range(0, 99);
        if (pick < 2) begin
          // Oversized property: the walk never finds its next token.
          push_word(TokProp);
          push_word($urandom() | 32'h0000_0100);
          push_word($urandom());
          repeat ($urandom_range(1, 3)) push_word($urandom());
          break;
        end else if (pick < 40) begin
          push_prop(($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 24)));
        end else if (pick < 50) begin
          push_word(TokNop);
        end else if (pick < 53) begin
          push_word(rand_bad_token());
          break;
        end else begin
          push_word(TokEndNode);
          open_n--;
        end
      end
    end
    // Cut the walk short, leave it for a restart, or end the blob on it.
    k    = $urandom_range(0, walk_q.size() - 1);
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      while (walk_q.size() > k + 1) walk_q.delete(walk_q.size() - 1);
      if (pick < 2) walk_q[k].last_word = 1'b1;
    end else if (pick < 5) begin
      walk_q[walk_q.size() - 1].last_word = 1'b1;
    end
  endfunction

  // Result side: random stalls, then take and check one result word.
  initial begin : result_sink
    int unsigned  stall;
    walk_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      if (stall != 0) begin
        res_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      do @(posedge clk_i); while (!res_valid_o);
      got.ev            = event_e'(event_res_o);
      got.node_off      = node_offset_o;
      got.level         = level_o;
      got.parent_off    = parent_offset_o;
      got.name_len      = name_length_o;
      got.prop_size     = prop_length_o;
      got.prop_name_off = prop_name_offset_o;
      got.data          = data_word_o;
      got.last_data     = last_data_o;
      got.finished      = finished_o;
      board.check_result(got);
    end
  end

  // Stimulus: directed opening, then random walks.
  initial begin : word_source
    int unsigned rand_target;
    board        = new();
    rst_ni       = 1'b0;
    word_valid_i = 1'b0;
    word_i       = '0;
    first_word_i = 1'b0;
    last_word_i  = 1'b0;
    res_ready_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A word with no walk running is dropped.
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    // Root with an empty name, an empty property, a five-byte property,
    // a nop and a named child; the blob ends on the root close.
    send_word(TokBeginNode, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(TokProp, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(TokProp, 1'b0, 1'b0);
    send_word(32'd5, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b0);
    send_word(TokNop, 1'b0, 1'b0);
    send_word(TokBeginNode, 1'b0, 1'b0);
    send_word(32'h6162_6300, 1'b0, 1'b0);
    send_word(TokEndNode, 1'b0, 1'b0);
    send_word(TokEndNode, 1'b0, 1'b1);
    // End token, unknown token, and a property with no node open.
    send_word(TokEnd, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(TokProp, 1'b1, 1'b0);
    // Maximum property length, cut off by the end of the blob.
    send_word(TokBeginNode, 1'b1, 1'b0);
    send_word(32'h7A00_0000, 1'b0, 1'b0);
    send_word(TokProp, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'hA5A5_5A5A, 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0000, 1'b0, 1'b1);

    // Random walks; idling is switched on or off per walk on each side.
    rand_target = board.words_parsed + RAND_WORDS;
    while (board.words_parsed < rand_target) begin
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      build_walk();
      foreach (walk_q[n]) send_word(walk_q[n].word, walk_q[n].first_word, walk_q[n].last_word);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_word($urandom(), 1'b0, 1'($urandom_range(0, 1)));
      end
    end
    word_valid_i <= 1'b0;

    // Drain the remaining results, then allow for any stray ones.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Parsed %0d words (%0d idle drops): %0d begins, %0d properties, %0d data words.",
             board.words_parsed, board.words_ignored, board.event_hits[EV_BEGIN],
             board.event_hits[EV_PROP], board.event_hits[EV_DATA]);
    $display("Walk ends: %0d closed, %0d end tokens, %0d unknown, %0d nesting, %0d truncated.",
             board.event_hits[EV_DONE], board.event_hits[EV_END_TOKEN],
             board.event_hits[EV_UNKNOWN], board.event_hits[EV_NESTING],
             board.event_hits[EV_TRUNC]);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have finished.
  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d results still expected.", board.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
